// ===== rtl/core/wdnr_pkg.sv =====
package wdnr_pkg;

  localparam int MANT_W      = 192;
  localparam int RES_W       = 96;
  localparam int WORD_W      = 64;
  localparam int RES_HIGH_W  = RES_W - WORD_W;
  localparam int SCALE_W     = 8;
  localparam int OUT_SCALE_W = 5;

  localparam int CHUNK_W     = 16;
  localparam int REM_W       = 4;
  localparam int ACC_W       = CHUNK_W + REM_W;
  localparam int NUM_CHUNKS  = MANT_W / CHUNK_W;
  localparam int CNT_W       = $clog2(NUM_CHUNKS);

  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 23;
  localparam int PROD_W      = ACC_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838861;

  localparam logic [REM_W-1:0] DIGIT_TEN  = 4'd10;
  localparam logic [REM_W-1:0] DIGIT_HALF = 4'd5;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_ROUND = 4'b1000
  } state_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] quot;
    logic [REM_W-1:0]   rem;
  } div_res_t;

endpackage

// ===== rtl/core/wdnr_in_if.sv =====
interface wdnr_in_if;
  import wdnr_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  mant_low;
  logic [WORD_W-1:0]  mant_mid;
  logic [WORD_W-1:0]  mant_high;
  logic [SCALE_W-1:0] in_scale;
  logic               in_sign;

  modport source (
    output valid, mant_low, mant_mid, mant_high, in_scale, in_sign,
    input  ready
  );

  modport sink (
    input  valid, mant_low, mant_mid, mant_high, in_scale, in_sign,
    output ready
  );

endinterface

// ===== rtl/core/wdnr_out_if.sv =====
interface wdnr_out_if;
  import wdnr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [WORD_W-1:0]      res_low;
  logic [RES_HIGH_W-1:0]  res_high;
  logic [OUT_SCALE_W-1:0] res_scale;
  logic                   res_sign;
  logic                   overflow_flag;

  modport source (
    output valid, res_low, res_high, res_scale, res_sign, overflow_flag,
    input  ready
  );

  modport sink (
    input  valid, res_low, res_high, res_scale, res_sign, overflow_flag,
    output ready
  );

endinterface

// ===== rtl/core/wdnr_div10_step.sv =====
module wdnr_div10_step
  import wdnr_pkg::*;
(
  input  logic [REM_W-1:0]   rem_in,
  input  logic [CHUNK_W-1:0] chunk,
  output div_res_t           res
);

  logic [ACC_W-1:0]   acc;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] quot;
  logic [ACC_W-1:0]   quot_ext;
  logic [ACC_W-1:0]   quot_x10;
  logic [ACC_W-1:0]   diff;

  assign acc      = {rem_in, chunk};
  assign prod     = PROD_W'(acc) * PROD_W'(RECIP_TEN);
  assign quot     = prod[RECIP_SHIFT +: CHUNK_W];
  assign quot_ext = ACC_W'(quot);
  assign quot_x10 = (quot_ext << 3) + (quot_ext << 1);
  assign diff     = acc - quot_x10;

  assign res.quot = quot;
  assign res.rem  = diff[REM_W-1:0];

endmodule

// ===== rtl/core/wide_decimal_narrow_round_top.sv =====
// Channel  Dir  Handshake                   Word
// in_ch    in   in_ch.valid / in_ch.ready   mant_low, mant_mid, mant_high, in_scale, in_sign
// out_ch   out  out_ch.valid / out_ch.ready res_low, res_high, res_scale, res_sign, overflow_flag
//
// From accept, a word runs N divide-by-ten steps and a final check before it is registered on out_ch;
// no new word is accepted until then. N = number of divide-by-ten steps (0 to 255).
// Each step runs the 16-bit chunk divider over the 12 mantissa chunks in ST_DIV, then ST_ROUND, then ST_CHECK.
// The single reciprocal-multiply chunk divider is reused for every chunk.
// Reset clears the sequencer and the output valid; no clearing pass.
// A finished word waits in the output register; a low out_ch.ready while a word waits stalls the check state.
module wide_decimal_narrow_round_top
  import wdnr_pkg::*;
#(
  parameter int MAX_SCALE = 28
) (
  input  logic       clk,
  input  logic       rst_n,
  wdnr_in_if.sink    in_ch,
  wdnr_out_if.source out_ch
);

  state_t                 state_r, state_nxt;
  logic [MANT_W-1:0]      mant_r, mant_nxt;
  logic [SCALE_W-1:0]     scale_r, scale_nxt;
  logic                   sign_r, sign_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]      res_low_r, res_low_nxt;
  logic [RES_HIGH_W-1:0]  res_high_r, res_high_nxt;
  logic [OUT_SCALE_W-1:0] res_scale_r, res_scale_nxt;
  logic                   res_sign_r, res_sign_nxt;
  logic                   ovf_r, ovf_nxt;

  div_res_t               step_res;
  logic                   wide;
  logic                   need_div;
  logic                   round_up;
  logic                   out_free;

  wdnr_div10_step u_div_step (
    .rem_in (rem_r),
    .chunk  (mant_r[MANT_W-1 -: CHUNK_W]),
    .res    (step_res)
  );

  assign wide     = |mant_r[MANT_W-1:RES_W];
  assign need_div = (scale_r > SCALE_W'(MAX_SCALE)) || (wide && (scale_r != '0));
  assign round_up = (rem_r > DIGIT_HALF) || ((rem_r == DIGIT_HALF) && mant_r[0]);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    mant_nxt      = mant_r;
    scale_nxt     = scale_r;
    sign_nxt      = sign_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_low_nxt   = res_low_r;
    res_high_nxt  = res_high_r;
    res_scale_nxt = res_scale_r;
    res_sign_nxt  = res_sign_r;
    ovf_nxt       = ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          mant_nxt  = {in_ch.mant_high, in_ch.mant_mid, in_ch.mant_low};
          scale_nxt = in_ch.in_scale;
          sign_nxt  = in_ch.in_sign;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (need_div) begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          res_low_nxt   = mant_r[WORD_W-1:0];
          res_high_nxt  = mant_r[RES_W-1:WORD_W];
          res_scale_nxt = scale_r[OUT_SCALE_W-1:0];
          res_sign_nxt  = sign_r;
          ovf_nxt       = wide && (scale_r == '0);
          state_nxt     = ST_IDLE;
        end
      end
      ST_DIV: begin
        mant_nxt = {mant_r[MANT_W-CHUNK_W-1:0], step_res.quot};
        rem_nxt  = step_res.rem;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_CHUNKS - 1)) begin
          scale_nxt = scale_r - 1'b1;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_up) begin
          mant_nxt = mant_r + MANT_W'(1);
        end
        state_nxt = ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mant_r      <= mant_nxt;
    scale_r     <= scale_nxt;
    sign_r      <= sign_nxt;
    rem_r       <= rem_nxt;
    res_low_r   <= res_low_nxt;
    res_high_r  <= res_high_nxt;
    res_scale_r <= res_scale_nxt;
    res_sign_r  <= res_sign_nxt;
    ovf_r       <= ovf_nxt;
  end

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.res_low       = res_low_r;
  assign out_ch.res_high      = res_high_r;
  assign out_ch.res_scale     = res_scale_r;
  assign out_ch.res_sign      = res_sign_r;
  assign out_ch.overflow_flag = ovf_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_rem_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (rem_r < DIGIT_TEN))
    else $error("dropped digit out of range");

  a_round_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |=> (state_r == ST_CHECK))
    else $error("round not followed by check");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= CNT_W'(NUM_CHUNKS - 1)))
    else $error("chunk counter past last chunk");

  a_ovf_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ovf_r) |-> (res_scale_r == '0))
    else $error("overflow with nonzero scale");

endmodule
